FILE: design/combined_lcg_shuffle_random_core_defines.svh
// assertion macros for the shuffled combined generator checker
// no dependencies; included by the checker file only
`ifndef COMBINED_LCG_SHUFFLE_RANDOM_CORE_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RANDOM_CORE_DEFINES_SVH

// condition now implies consequence in the same cycle
`define CLSR_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition now implies consequence in the next cycle
`define CLSR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/clsr_pkg.sv
// shared types, constants and modular fold helpers for the shuffled generator
// no dependencies
`default_nettype none

package clsr_pkg;

	localparam logic [30:0] MOD1 = 31'd2147483563;
	localparam logic [30:0] MOD2 = 31'd2147483399;
	localparam logic [15:0] MUL1 = 16'd40014;
	localparam logic [15:0] MUL2 = 16'd40692;
	// 2^31 minus each modulus
	localparam logic [7:0] FOLD1 = 8'd85;
	localparam logic [7:0] FOLD2 = 8'd249;
	localparam logic [30:0] RESET_STATE = 31'd123456789;
	localparam logic [31:0] RESET_SEED = 32'd123456789;
	localparam int unsigned WARM_STEPS = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_MUL,
		ST_INIT_RED,
		ST_MUL,
		ST_RED,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic init_load;
		logic op_seed;
		logic mul_x;
		logic mul_y;
		logic tbl_rd;
		logic red_x;
		logic red_y;
		logic init_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic seed_nonpos;
		logic x_zero;
		logic init_done;
	} status_t;

	// product is hi*2^31 + lo, and 2^31 = MOD1 + FOLD1
	function automatic logic [30:0] fold_mod1(input logic [46:0] p);
		logic [31:0] s;
		begin
			s = 32'(p[30:0]) + 32'(p[46:31]) * 32'(FOLD1);
			if (s >= 32'(MOD1))
				s = s - 32'(MOD1);
			return s[30:0];
		end
	endfunction

	function automatic logic [30:0] fold_mod2(input logic [46:0] p);
		logic [31:0] s;
		begin
			s = 32'(p[30:0]) + 32'(p[46:31]) * 32'(FOLD2);
			if (s >= 32'(MOD2))
				s = s - 32'(MOD2);
			return s[30:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/combined_lcg_shuffle_random_core.sv
// top level of the shuffled combined congruential generator
// depends on clsr_pkg, clsr_ctrl, clsr_dpath (and clsr_ram below it)
//
// channel   direction  signals                          moves per transfer
// input     in         in_valid, in_ready, restart       one request
// output    out        out_valid, out_ready, random_value one 31-bit value
// config    in         cfg_wr_en, cfg_wr_data            seed register write
//
// a plain request walks the transfer cycle (both multiplies, table read),
// modular fold of both generators, then shuffle and load of the output register once it is free
// a table init (restart with non-positive seed, or a plain request with the first generator at zero)
// runs the serial warm-up loop through the first generator's multiplier, a multiply then a fold per step
// reset loads the generator state and clears the table valid bits at once, no clearing pass
// a full output register holds its value until its transfer completes
`default_nettype none

module combined_lcg_shuffle_random_core #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [30:0]      random_value,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);
	import clsr_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: accepts a request only when idle, walks warm-up and step cycles
	clsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: generator state, shuffle table memory, output register
	clsr_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.status       (status),
		.random_value (random_value)
	);

endmodule

`default_nettype wire

FILE: design/clsr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/clsr_ctrl.sv
// sequencing state machine: handshakes, warm-up loop and output register valid
// depends on clsr_pkg
`default_nettype none

module clsr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              restart,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire clsr_pkg::status_t status,
	output clsr_pkg::cmd_t         cmd
);
	import clsr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   init_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		init_need = restart ? status.seed_nonpos : status.x_zero;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op_seed = restart;
					if (init_need) begin
						cmd.init_load = 1'b1;
						state_d       = ST_INIT_MUL;
					end else begin
						cmd.mul_x  = 1'b1;
						cmd.mul_y  = 1'b1;
						cmd.tbl_rd = 1'b1;
						state_d    = ST_RED;
					end
				end
			end
			ST_INIT_MUL: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_INIT_RED;
			end
			ST_INIT_RED: begin
				cmd.red_x     = 1'b1;
				cmd.init_step = 1'b1;
				state_d       = status.init_done ? ST_MUL : ST_INIT_MUL;
			end
			ST_MUL: begin
				cmd.mul_x  = 1'b1;
				cmd.mul_y  = 1'b1;
				cmd.tbl_rd = 1'b1;
				state_d    = ST_RED;
			end
			ST_RED: begin
				cmd.red_x = 1'b1;
				cmd.red_y = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (cmd.finish)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: design/clsr_dpath.sv
// generator datapath: seed register, two modular multipliers, shuffle table, output register
// depends on clsr_pkg and clsr_ram
`default_nettype none

module clsr_dpath #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [31:0]       cfg_wr_data,
	input  wire clsr_pkg::cmd_t    cmd,
	output clsr_pkg::status_t      status,
	output logic [30:0]            random_value
);
	import clsr_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 8);
	localparam logic [CW-1:0] INIT_LAST = CW'(TABLE_DEPTH + 7);
	localparam logic [CW-1:0] WARM = CW'(WARM_STEPS);
	localparam logic [31:0] SLOT_DIV = 32'(1 + (32'(MOD1) - 32'd1) / TABLE_DEPTH);

	logic [31:0]          seed_q;
	logic [30:0]          x_q, y_q, last_q;
	logic [CW-1:0]        cnt_q;
	logic [TABLE_DEPTH-1:0] tbl_valid_q;
	logic                 rd_valid_q;
	logic [46:0]          prod1_q, prod2_q;
	logic [IW-1:0]        idx_q;
	logic [30:0]          random_value_q;

	logic [30:0]          seed_mag, mag, mul_op, x_next, y_next;
	logic [30:0]          ram_rd, tbl_rd_val, shuffled;
	logic [31:0]          diff, wrapped;
	logic [TABLE_DEPTH:0] ge;
	logic [IW-1:0]        idx_next, init_addr, wr_addr;
	logic [30:0]          wr_data;
	logic                 wr_en, init_wr;

	// seed magnitude for table init, zero maps to one, most negative saturates
	always_comb begin
		if (seed_q == 32'd0)
			seed_mag = 31'd1;
		else if (seed_q == 32'h8000_0000)
			seed_mag = 31'h7fff_ffff;
		else
			seed_mag = 31'((~seed_q) + 32'd1);
	end

	assign mag    = cmd.op_seed ? seed_mag : 31'd1;
	assign mul_op = cmd.op_seed ? seed_q[30:0] : x_q;
	assign x_next = fold_mod1(prod1_q);
	assign y_next = fold_mod2(prod2_q);

	assign status.seed_nonpos = seed_q[31] || (seed_q == 32'd0);
	assign status.x_zero      = (x_q == 31'd0);
	assign status.init_done   = (cnt_q == INIT_LAST);

	// table slot from the previous output: count thresholds at multiples of the slot size
	assign ge[0]           = 1'b1;
	assign ge[TABLE_DEPTH] = 1'b0;
	for (genvar k = 1; k < TABLE_DEPTH; k++) begin : g_thr
		localparam logic [31:0] THR = 32'(k) * SLOT_DIV;
		assign ge[k] = ({1'b0, last_q} >= THR);
	end

	always_comb begin
		idx_next = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (ge[k] && !ge[k+1])
				idx_next = idx_next | IW'(k);
		end
	end

	// warm-up writes go from the top slot down to slot zero
	assign init_addr = IW'(INIT_LAST - cnt_q);
	assign init_wr   = cmd.init_step && (cnt_q >= WARM);
	assign wr_en     = init_wr || cmd.finish;
	assign wr_addr   = cmd.finish ? idx_q : init_addr;
	assign wr_data   = cmd.finish ? x_q : x_next;

	clsr_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.tbl_rd),
		.rd_addr (idx_next),
		.rd_data (ram_rd)
	);

	// slots never written read as zero
	assign tbl_rd_val = rd_valid_q ? ram_rd : 31'd0;
	assign diff       = {1'b0, tbl_rd_val} - {1'b0, y_q};
	assign wrapped    = (diff[31] || diff == 32'd0) ? diff + (32'(MOD1) - 32'd1) : diff;
	assign shuffled   = wrapped[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= RESET_SEED;
			x_q         <= RESET_STATE;
			y_q         <= RESET_STATE;
			last_q      <= 31'd0;
			cnt_q       <= '0;
			tbl_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				seed_q <= cfg_wr_data;
			if (cmd.init_load) begin
				x_q   <= mag;
				y_q   <= mag;
				cnt_q <= '0;
			end
			if (cmd.red_x)
				x_q <= x_next;
			if (cmd.red_y)
				y_q <= y_next;
			if (cmd.init_step) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == INIT_LAST)
					last_q <= x_next;
			end
			if (cmd.finish)
				last_q <= shuffled;
			if (wr_en)
				tbl_valid_q[wr_addr] <= 1'b1;
			if (cmd.tbl_rd)
				rd_valid_q <= tbl_valid_q[idx_next];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_x)
			prod1_q <= 47'(mul_op) * 47'(MUL1);
		if (cmd.mul_y)
			prod2_q <= 47'(y_q) * 47'(MUL2);
		if (cmd.tbl_rd)
			idx_q <= idx_next;
		if (cmd.finish)
			random_value_q <= shuffled;
	end

	assign random_value = random_value_q;

endmodule

`default_nettype wire

FILE: design/clsr_checker.sv
// port-level checker for the shuffled generator, bound to the top level
// depends on clsr_pkg and combined_lcg_shuffle_random_core_defines.svh
`default_nettype none
`include "combined_lcg_shuffle_random_core_defines.svh"

module clsr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [30:0] random_value
);
	import clsr_pkg::*;

	// a stalled result holds its value
	`CLSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(random_value), "output changed while stalled")

	// every delivered value lies in 1 to MOD1 minus 1
	`CLSR_ASSERT_NOW(a_out_range, clk, arst_n, out_valid, (random_value != 31'd0) && (random_value < MOD1), "output value out of range")

	// one request at a time: busy right after an input transfer
	`CLSR_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while busy")

	// a new result appears only at the end of a busy step
	`CLSR_ASSERT_NOW(a_result_from_step, clk, arst_n, $rose(out_valid), $past(!in_ready), "result without a step")

endmodule

bind combined_lcg_shuffle_random_core clsr_checker u_clsr_checker (.*);

`default_nettype wire

FILE: dv/tb_combined_lcg_shuffle_random_core.sv
// self-checking bench for combined_lcg_shuffle_random_core: directed seed corners then random
// phases; depends only on the core and its submodules, predicts each value with its own generator
`default_nettype none

module tb_combined_lcg_shuffle_random_core;

	// geometry and generator constants, kept local to the bench
	localparam int TABLE_LEN = 32;
	localparam longint unsigned GEN1_MOD = 64'd2147483563;
	localparam longint unsigned GEN2_MOD = 64'd2147483399;
	localparam longint unsigned GEN1_MUL = 64'd40014;
	localparam longint unsigned GEN2_MUL = 64'd40692;
	localparam longint unsigned SLOT_WIDTH = 64'd1 + (GEN1_MOD - 64'd1) / TABLE_LEN;
	localparam longint MAG_CAP = 64'sh7FFF_FFFF;
	localparam longint WRAP_ADD = 64'sd2147483562;
	localparam logic [31:0] SEED_RESET = 32'd123456789;
	localparam logic [31:0] SEED_MOD1 = 32'd2147483563;
	localparam logic [31:0] SEED_MOD2 = 32'd2147483399;
	localparam logic [31:0] SEED_MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] SEED_MOST_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SEED_MINUS_ONE = 32'hFFFF_FFFF;
	localparam logic [31:0] SEED_NEG_FULL = 32'h8000_0001;
	// warm-up restart is the slowest transfer; this is many times its length
	localparam int IDLE_LIMIT = 1000;
	// cycles of quiet after the last value before a seed write or the end of the run
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1350;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] random_value;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = 32'd0;

	combined_lcg_shuffle_random_core #(
		.TABLE_DEPTH(TABLE_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_value(random_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state: seed register copy, both generators, last value, shuffle slots
	logic signed [31:0] seed_reg = SEED_RESET;
	logic [30:0] gen1 = 31'd123456789;
	logic [30:0] gen2 = 31'd123456789;
	logic [30:0] prev_value = 31'd0;
	logic [30:0] shuffle_slots [TABLE_LEN] = '{default: 31'd0};

	// restart flags waiting for the driver, and values the core still owes us
	bit          queued_restarts [$];
	logic [30:0] owed_values [$];

	// handshake bookkeeping between the sampling edge and the driving edge
	bit in_accepted = 1'b0;
	bit out_accepted = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	bit steady_in = 1'b0;
	bit steady_out = 1'b0;
	int idle_cycles = 0;
	int mismatches = 0;

	function automatic logic [30:0] step_gen1(input logic [30:0] x);
		longint unsigned p;
		begin
			p = 64'(x) * GEN1_MUL;
			return 31'(p % GEN1_MOD);
		end
	endfunction

	function automatic logic [30:0] step_gen2(input logic [30:0] y);
		longint unsigned p;
		begin
			p = 64'(y) * GEN2_MUL;
			return 31'(p % GEN2_MOD);
		end
	endfunction

	// advance the shuffled generator by one request and return the value it yields
	task automatic next_random(input bit reload, output logic [30:0] value);
		longint start;
		longint mag;
		longint diff;
		longint unsigned slot;
		int k;
		begin
			start = reload ? longint'(seed_reg) : longint'(gen1);
			if (start <= 0) begin
				// zero or negative: reseed both generators with the magnitude and refill
				mag = (start == 0) ? 64'sd1 : -start;
				if (mag > MAG_CAP)
					mag = MAG_CAP;
				gen1 = mag[30:0];
				gen2 = mag[30:0];
				for (k = TABLE_LEN + 7; k >= 0; k--) begin
					gen1 = step_gen1(gen1);
					if (k < TABLE_LEN)
						shuffle_slots[k] = gen1;
				end
				prev_value = shuffle_slots[0];
			end else begin
				gen1 = start[30:0];
			end
			gen1 = step_gen1(gen1);
			gen2 = step_gen2(gen2);
			slot = 64'(prev_value) / SLOT_WIDTH;
			if (slot >= TABLE_LEN)
				slot = TABLE_LEN - 1;
			diff = longint'(shuffle_slots[slot]) - longint'(gen2);
			shuffle_slots[slot] = gen1;
			if (diff < 1)
				diff = diff + WRAP_ADD;
			prev_value = diff[30:0];
			value = prev_value;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sampling edge: predict on each request transfer, check each value transfer
	always @(posedge clk) begin
		logic [30:0] predicted;
		logic [30:0] want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				next_random(restart, predicted);
				owed_values.push_back(predicted);
				in_accepted = 1'b1;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				out_accepted = 1'b1;
				moved = 1'b1;
				if (owed_values.size() == 0) begin
					$error("random_value: nothing expected, actual %0d", random_value);
					mismatches++;
				end else begin
					want = owed_values.pop_front();
					if (random_value !== want) begin
						$error("random_value: expected %0d, actual %0d", want, random_value);
						mismatches++;
					end
				end
			end
			// watchdog on cycles with no transfer on either channel
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// request driver: holds valid until the transfer, then waits a drawn gap
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if (in_accepted) begin
				in_accepted = 1'b0;
				in_gap = steady_in ? 0 : int'($urandom_range(0, 8));
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (queued_restarts.size() != 0) begin
				restart <= queued_restarts.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// value sink: stalls a drawn number of cycles after each transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_accepted) begin
				out_accepted = 1'b0;
				out_gap = steady_out ? 0 : int'($urandom_range(0, 8));
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// wait until every queued request has gone through and its value came back
	task automatic drain;
		begin
			while (queued_restarts.size() != 0 || in_valid || owed_values.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	// seed register write, only while the core is idle
	task automatic load_seed(input logic [31:0] value);
		begin
			drain();
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= value;
			seed_reg = value;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
		end
	endtask

	initial begin
		int total;
		int count;
		int i;
		logic [31:0] seed;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// steps on the zero table from reset, then a restart with the reset seed
		queued_restarts.push_back(1'b0);
		queued_restarts.push_back(1'b0);
		queued_restarts.push_back(1'b0);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		// zero seed warms up with magnitude one
		load_seed(32'd0);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		load_seed(SEED_MINUS_ONE);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		// most negative seed saturates its magnitude
		load_seed(SEED_MOST_NEG);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		// positive seed above the first modulus is used as is
		load_seed(SEED_MOST_POS);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		// seed equal to the first modulus drives the first generator to zero,
		// the next plain step then warms up with magnitude one
		load_seed(SEED_MOD1);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		load_seed(SEED_NEG_FULL);
		queued_restarts.push_back(1'b1);
		load_seed(SEED_MOD2);
		queued_restarts.push_back(1'b1);
		queued_restarts.push_back(1'b0);
		load_seed(32'd1);
		queued_restarts.push_back(1'b1);

		// random phases: a seed, usually a restart, then a run with rare restarts
		total = 0;
		while (total < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0, 1: seed = $urandom | SEED_MOST_NEG;
				2: seed = $urandom & SEED_MOST_POS;
				3: seed = -32'($urandom_range(0, 1000));
				4: seed = $urandom;
				default: begin
					case ($urandom_range(0, 6))
						0: seed = 32'd0;
						1: seed = SEED_MOST_NEG;
						2: seed = SEED_MOST_POS;
						3: seed = SEED_MOD1;
						4: seed = SEED_MINUS_ONE;
						5: seed = SEED_RESET;
						default: seed = 32'd1;
					endcase
				end
			endcase
			load_seed(seed);
			steady_in = ($urandom_range(0, 3) == 0);
			steady_out = ($urandom_range(0, 3) == 0);
			count = $urandom_range(20, 60);
			queued_restarts.push_back($urandom_range(0, 3) != 0);
			for (i = 1; i < count; i++)
				queued_restarts.push_back($urandom_range(0, 19) == 0);
			total += count;
		end

		drain();
		if (mismatches == 0 && owed_values.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/clsr_pkg.sv
design/clsr_ram.sv
design/clsr_ctrl.sv
design/clsr_dpath.sv
design/combined_lcg_shuffle_random_core.sv
design/clsr_checker.sv
dv/tb_combined_lcg_shuffle_random_core.sv
